>>> sv/spbe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sensor packet buffer.
// Used by spbe_ctrl, spbe_dp and sensor_packet_buffer_energy; depends on nothing.
package spbe_pkg;

	localparam int DEPTH     = 8;
	localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int ID_W      = 16;
	localparam int TEMP_W    = 6;
	localparam int HUM_W     = 7;
	localparam int ENTRY_W   = ID_W + TEMP_W + HUM_W;
	localparam int DIST_W    = 8;
	localparam int ENERGY_W  = 20;
	localparam int COST_W    = 2 * DIST_W + 1;
	localparam int CFG_IDX_W = 1;

	localparam logic [COST_W-1:0]   COST_BASE      = COST_W'(5);
	localparam logic [DIST_W-1:0]   DIST_RESET     = DIST_W'(10);
	localparam logic [ENERGY_W-1:0] ENERGY_RESET   = ENERGY_W'(100000);
	localparam logic [PTR_W-1:0]    PTR_LAST       = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0]    FILL_FULL      = CNT_W'(DEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_LINK_DISTANCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_START_ENERGY  = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		EV_ADDED     = 3'd0,
		EV_DROPPED   = 3'd1,
		EV_SENT      = 3'd2,
		EV_NOT_SENT  = 3'd3,
		EV_EMPTY     = 3'd4,
		EV_FLUSHED   = 3'd5
	} event_t;

	// Command word from the controller to the datapath
	typedef struct packed {
		logic capture;   // register the request beat
		logic fetch;     // read head entry, form transmit cost
		logic exec;      // update ring, pointers and energy total
		logic load;      // load the result register
	} cmd_t;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		next_slot = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

>>> sv/spbe_ctrl.sv
`timescale 1ns / 1ps
// Controller of the sensor packet buffer: sequences one request at a time.
// Depends on spbe_pkg.
module spbe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_ready,
	output logic           out_valid,
	output spbe_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load;

	assign load      = (state_q == S_RESP) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.fetch   = (state_q == S_FETCH);
		cmd.exec    = (state_q == S_EXEC);
		cmd.load    = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_FETCH;
				end
				S_FETCH: state_q <= S_EXEC;
				S_EXEC:  state_q <= S_RESP;
				S_RESP: begin
					// hold until the result register is free
					if (load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/spbe_dp.sv
`timescale 1ns / 1ps
// Datapath of the sensor packet buffer: packet ring, pointers, energy total,
// configuration registers and result register. Depends on spbe_pkg.
module spbe_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spbe_pkg::cmd_t                     cmd,
	input  logic                               cfg_we,
	input  logic [spbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spbe_pkg::ENERGY_W-1:0]      cfg_data,
	input  logic [1:0]                         op,
	input  logic [spbe_pkg::ID_W-1:0]          packet_id,
	input  logic [spbe_pkg::TEMP_W-1:0]        temperature,
	input  logic [spbe_pkg::HUM_W-1:0]         humidity,
	input  logic                               send_granted,
	output logic [2:0]                         event_res,
	output logic [spbe_pkg::ID_W-1:0]          dropped_id,
	output logic [spbe_pkg::ID_W-1:0]          sent_id,
	output logic [spbe_pkg::TEMP_W-1:0]        sent_temperature,
	output logic [spbe_pkg::HUM_W-1:0]         sent_humidity,
	output logic [spbe_pkg::CNT_W-1:0]         fill_level,
	output logic [spbe_pkg::ENERGY_W-1:0]      energy_left
);

	// Request registers
	logic [1:0]                      op_q;
	logic [spbe_pkg::ENTRY_W-1:0]    wr_entry_q;
	logic                            grant_q;

	// Ring and its control
	logic [spbe_pkg::ENTRY_W-1:0]    mem [spbe_pkg::DEPTH];
	logic [spbe_pkg::PTR_W-1:0]      head_q;
	logic [spbe_pkg::PTR_W-1:0]      tail_q;
	logic [spbe_pkg::CNT_W-1:0]      fill_q;
	logic [spbe_pkg::ENERGY_W-1:0]   used_q;

	// Configuration
	logic [spbe_pkg::DIST_W-1:0]     dist_q;
	logic [spbe_pkg::ENERGY_W-1:0]   start_q;

	// Fetch stage
	logic [spbe_pkg::ENTRY_W-1:0]    rd_s1;
	logic [spbe_pkg::COST_W-1:0]     cost_s1;

	// Execute stage
	spbe_pkg::event_t                ev_s2;

	logic                            wr_en;
	logic [spbe_pkg::ENERGY_W:0]     used_sum;
	logic [spbe_pkg::ENERGY_W-1:0]   left_val;
	logic                            is_sent;
	logic                            is_drop;

	assign used_sum = {1'b0, used_q} + (spbe_pkg::ENERGY_W + 1)'(cost_s1);
	assign left_val = (start_q > used_q) ? (start_q - used_q) : '0;
	assign wr_en    = cmd.exec && !op_q[1] && !op_q[0];
	assign is_sent  = (ev_s2 == spbe_pkg::EV_SENT);
	assign is_drop  = (ev_s2 == spbe_pkg::EV_DROPPED);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= op;
			wr_entry_q <= {packet_id, temperature, humidity};
			grant_q    <= send_granted;
		end
		if (cmd.fetch) begin
			rd_s1   <= mem[head_q];
			cost_s1 <= spbe_pkg::COST_W'(dist_q) * spbe_pkg::COST_W'(dist_q)
				+ spbe_pkg::COST_BASE;
		end
		if (wr_en) begin
			mem[tail_q] <= wr_entry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			used_q  <= '0;
			dist_q  <= spbe_pkg::DIST_RESET;
			start_q <= spbe_pkg::ENERGY_RESET;
			ev_s2   <= spbe_pkg::EV_ADDED;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					spbe_pkg::CFG_LINK_DISTANCE: dist_q  <= cfg_data[spbe_pkg::DIST_W-1:0];
					spbe_pkg::CFG_START_ENERGY:  start_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.exec) begin
				priority if (op_q[1]) begin
					head_q <= '0;
					tail_q <= '0;
					fill_q <= '0;
					ev_s2  <= spbe_pkg::EV_FLUSHED;
				end else if (op_q[0]) begin
					priority if (fill_q == '0) begin
						ev_s2 <= spbe_pkg::EV_EMPTY;
					end else if (!grant_q) begin
						ev_s2 <= spbe_pkg::EV_NOT_SENT;
					end else begin
						head_q <= spbe_pkg::next_slot(head_q);
						fill_q <= fill_q - spbe_pkg::CNT_W'(1);
						used_q <= used_sum[spbe_pkg::ENERGY_W] ? '1
							: used_sum[spbe_pkg::ENERGY_W-1:0];
						ev_s2  <= spbe_pkg::EV_SENT;
					end
				end else begin
					tail_q <= spbe_pkg::next_slot(tail_q);
					if (fill_q == spbe_pkg::FILL_FULL) begin
						// drop oldest, count stays at full
						head_q <= spbe_pkg::next_slot(head_q);
						ev_s2  <= spbe_pkg::EV_DROPPED;
					end else begin
						fill_q <= fill_q + spbe_pkg::CNT_W'(1);
						ev_s2  <= spbe_pkg::EV_ADDED;
					end
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			event_res        <= ev_s2;
			dropped_id       <= is_drop ? rd_s1[spbe_pkg::ENTRY_W-1 -: spbe_pkg::ID_W] : '0;
			sent_id          <= is_sent ? rd_s1[spbe_pkg::ENTRY_W-1 -: spbe_pkg::ID_W] : '0;
			sent_temperature <= is_sent
				? rd_s1[spbe_pkg::HUM_W +: spbe_pkg::TEMP_W] : '0;
			sent_humidity    <= is_sent ? rd_s1[spbe_pkg::HUM_W-1:0] : '0;
			fill_level       <= fill_q;
			energy_left      <= left_val;
		end
	end

endmodule

>>> sv/sensor_packet_buffer_energy.sv
`timescale 1ns / 1ps
// Sensor packet buffer with radio energy accounting: ring of DEPTH packets
// that drops the oldest on a full enqueue and charges 5 + distance^2 per send.
// Result beat: registered on leaving respond, after fetch and execute. A new
// request is taken only after the last leaves respond, set by the fetch/execute/
// respond sequence of the controller around the single ring read port.
// Reset: pointers, fill count and energy total clear; link_distance 10,
// start_energy 100000. Ring contents undefined until written; no clearing pass.
module sensor_packet_buffer_energy (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         op,
	input  logic [spbe_pkg::ID_W-1:0]          packet_id,
	input  logic [spbe_pkg::TEMP_W-1:0]        temperature,
	input  logic [spbe_pkg::HUM_W-1:0]         humidity,
	input  logic                               send_granted,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         event_res,
	output logic [spbe_pkg::ID_W-1:0]          dropped_id,
	output logic [spbe_pkg::ID_W-1:0]          sent_id,
	output logic [spbe_pkg::TEMP_W-1:0]        sent_temperature,
	output logic [spbe_pkg::HUM_W-1:0]         sent_humidity,
	output logic [spbe_pkg::CNT_W-1:0]         fill_level,
	output logic [spbe_pkg::ENERGY_W-1:0]      energy_left,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [spbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spbe_pkg::ENERGY_W-1:0]      cfg_data
);

	spbe_pkg::cmd_t cmd;

	// Configuration beats are always taken and land at once; send them only
	// while no request is in flight.
	assign cfg_ready = 1'b1;

	// Controller: accept a request beat, step it through fetch and execute,
	// then hold in respond until the result register is free. A finished
	// result may sit in the result register while the next beat is taken.
	spbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Datapath: the ring itself, head and tail pointers, fill count,
	// saturating energy total and the result register.
	spbe_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.op               (op),
		.packet_id        (packet_id),
		.temperature      (temperature),
		.humidity         (humidity),
		.send_granted     (send_granted),
		.event_res        (event_res),
		.dropped_id       (dropped_id),
		.sent_id          (sent_id),
		.sent_temperature (sent_temperature),
		.sent_humidity    (sent_humidity),
		.fill_level       (fill_level),
		.energy_left      (energy_left)
	);

endmodule
